[rtl/core/amma_pkg.sv]
package amma_pkg;

  localparam int MaxWindow = 16;
  localparam int HistAw    = $clog2(MaxWindow);
  localparam int LenW      = $clog2(MaxWindow + 1);
  localparam int AxisW     = 16;
  localparam int MagW      = 16;
  localparam int SqW       = 32;
  localparam int SumW      = 20;
  localparam int AvgW      = 15;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;
  localparam int RootSteps = SqW / 2;
  localparam int DivStepW  = $clog2(SumW);
  localparam int QDepth    = 2;
  localparam int QAw       = $clog2(QDepth);

  localparam logic [AvgW-1:0] AvgMax   = {AvgW{1'b1}};
  localparam logic [LenW-1:0] WlReset  = LenW'(10);
  localparam logic [SqW-1:0]  RootTop  = SqW'(1) << (SqW - 2);

  // register indexes (paddr word index)
  localparam logic [AddrW-3:0] RegWindowLength = '0;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            restart;
  } amma_mag_t;

  typedef struct packed {
    logic            clear;
    logic [LenW-1:0] len;
  } amma_cfg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_ROOT,
    F_PUSH
  } amma_front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } amma_back_state_t;

  // zero acts as one, anything above the history depth saturates
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] wl);
    logic [LenW-1:0] n;
    n = wl;
    if (n == '0) begin
      n = LenW'(1);
    end
    if (n > LenW'(MaxWindow)) begin
      n = LenW'(MaxWindow);
    end
    return n;
  endfunction

  function automatic logic [AxisW-1:0] axis_abs(input logic signed [AxisW-1:0] v);
    logic [AxisW-1:0] r;
    r = v[AxisW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

[rtl/core/amma_if.sv]
interface amma_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [amma_pkg::AxisW-1:0]     accel_x;
  logic signed [amma_pkg::AxisW-1:0]     accel_y;
  logic signed [amma_pkg::AxisW-1:0]     accel_z;
  logic                                  restart;

  modport source (output valid, accel_x, accel_y, accel_z, restart, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, restart, output ready);
endinterface

interface amma_out_if;
  logic                        valid;
  logic                        ready;
  logic [amma_pkg::AvgW-1:0]   average_magnitude;
  logic                        clipped;

  modport source (output valid, average_magnitude, clipped, input ready);
  modport sink (input valid, average_magnitude, clipped, output ready);
endinterface

[rtl/core/amma_front.sv]
module amma_front (
  input  logic                clk,
  input  logic                rst,
  amma_in_if.sink             samples,
  output logic                push,
  output amma_pkg::amma_mag_t push_data,
  input  logic                q_full
);

  amma_pkg::amma_front_state_t state, state_next;

  logic [amma_pkg::AxisW-1:0] ax, ay, az;
  logic                       restart;
  logic [1:0]                 sq_idx;
  logic [amma_pkg::SqW-1:0]   acc;
  logic [amma_pkg::SqW-1:0]   rem_v;
  logic [amma_pkg::SqW-1:0]   root;
  logic [amma_pkg::SqW-1:0]   probe;
  logic [$clog2(amma_pkg::RootSteps)-1:0] step;

  logic [amma_pkg::AxisW-1:0] op;
  logic [amma_pkg::SqW-1:0]   acc_next;
  logic [amma_pkg::SqW-1:0]   trial;
  logic                       take;

  always_comb begin
    case (sq_idx)
      2'd0:    op = ax;
      2'd1:    op = ay;
      default: op = az;
    endcase
    acc_next = acc + (amma_pkg::SqW'(op) * amma_pkg::SqW'(op));
    trial    = root + probe;
  end

  always_comb begin
    state_next        = state;
    samples.ready     = 1'b0;
    push              = 1'b0;
    push_data.mag     = root[amma_pkg::MagW-1:0];
    push_data.restart = restart;
    take              = 1'b0;
    case (state)
      amma_pkg::F_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          take       = 1'b1;
          state_next = amma_pkg::F_SQUARE;
        end
      end
      amma_pkg::F_SQUARE: begin
        if (sq_idx == 2'd2) begin
          state_next = amma_pkg::F_ROOT;
        end
      end
      amma_pkg::F_ROOT: begin
        if (step == '1) begin
          state_next = amma_pkg::F_PUSH;
        end
      end
      amma_pkg::F_PUSH: begin
        push = !q_full;
        if (!q_full) begin
          state_next = amma_pkg::F_IDLE;
        end
      end
      default: state_next = amma_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amma_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      amma_pkg::F_IDLE: begin
        if (take) begin
          ax      <= amma_pkg::axis_abs(samples.accel_x);
          ay      <= amma_pkg::axis_abs(samples.accel_y);
          az      <= amma_pkg::axis_abs(samples.accel_z);
          restart <= samples.restart;
          acc     <= '0;
          sq_idx  <= '0;
        end
      end
      amma_pkg::F_SQUARE: begin
        acc    <= acc_next;
        sq_idx <= sq_idx + 2'd1;
        rem_v  <= acc_next;
        root   <= '0;
        probe  <= amma_pkg::RootTop;
        step   <= '0;
      end
      amma_pkg::F_ROOT: begin
        // one result bit per cycle, restoring method
        if (rem_v >= trial) begin
          rem_v <= rem_v - trial;
          root  <= (root >> 1) + probe;
        end else begin
          root  <= root >> 1;
        end
        probe <= probe >> 2;
        step  <= step + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/amma_fifo.sv]
module amma_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  amma_pkg::amma_mag_t push_data,
  output logic                full,
  input  logic                pop,
  output amma_pkg::amma_mag_t pop_data,
  output logic                empty
);

  amma_pkg::amma_mag_t        mem [amma_pkg::QDepth];
  logic [amma_pkg::QAw-1:0]   wr_ptr, rd_ptr;
  logic [amma_pkg::QAw:0]     count;

  assign full     = (count == (amma_pkg::QAw+1)'(amma_pkg::QDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/core/amma_back.sv]
module amma_back (
  input  logic                clk,
  input  logic                rst,
  input  amma_pkg::amma_cfg_t cfg,
  input  logic                q_empty,
  input  amma_pkg::amma_mag_t q_data,
  output logic                pop,
  amma_out_if.source          averages
);

  amma_pkg::amma_back_state_t state, state_next;

  logic [amma_pkg::MagW-1:0]   hist [amma_pkg::MaxWindow];
  logic [amma_pkg::SumW-1:0]   sum;
  logic [amma_pkg::LenW-1:0]   fill;
  logic [amma_pkg::HistAw-1:0] wp;

  logic [amma_pkg::SumW-1:0]   dividend;
  logic [amma_pkg::SumW-1:0]   quo;
  logic [amma_pkg::LenW-1:0]   drem;
  logic [amma_pkg::DivStepW-1:0] dstep;

  logic                        out_valid;
  logic [amma_pkg::AvgW-1:0]   out_avg;
  logic                        out_clip;

  // window update for the item at the queue head
  logic [amma_pkg::SumW-1:0]   base_sum, sum_next;
  logic [amma_pkg::LenW-1:0]   base_fill, fill_next;
  logic [amma_pkg::HistAw-1:0] base_wp, ptr, wp_next;
  logic [amma_pkg::LenW-1:0]   ptr_inc;
  logic                        was_full;
  logic                        produce;

  logic [amma_pkg::LenW:0]     shifted;
  logic                        qbit;
  logic                        load_out;
  logic                        clip_now;

  always_comb begin
    base_sum  = q_data.restart ? '0 : sum;
    base_fill = q_data.restart ? '0 : fill;
    base_wp   = q_data.restart ? '0 : wp;
    ptr       = (amma_pkg::LenW'(base_wp) >= cfg.len) ? '0 : base_wp;
    was_full  = (base_fill >= cfg.len);
    sum_next  = base_sum - (was_full ? amma_pkg::SumW'(hist[ptr]) : '0)
                + amma_pkg::SumW'(q_data.mag);
    fill_next = was_full ? base_fill : base_fill + 1'b1;
    ptr_inc   = amma_pkg::LenW'(ptr) + 1'b1;
    wp_next   = (ptr_inc >= cfg.len) ? '0 : ptr_inc[amma_pkg::HistAw-1:0];
    produce   = (fill_next >= cfg.len);

    shifted   = {drem, dividend[amma_pkg::SumW-1]};
    qbit      = (shifted >= (amma_pkg::LenW+1)'(cfg.len));
    clip_now  = (quo > amma_pkg::SumW'(amma_pkg::AvgMax));
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      amma_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (produce) begin
            state_next = amma_pkg::B_DIV;
          end
        end
      end
      amma_pkg::B_DIV: begin
        if (dstep == amma_pkg::DivStepW'(amma_pkg::SumW - 1)) begin
          state_next = amma_pkg::B_DONE;
        end
      end
      amma_pkg::B_DONE: begin
        if (!out_valid || averages.ready) begin
          load_out   = 1'b1;
          state_next = amma_pkg::B_IDLE;
        end
      end
      default: state_next = amma_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= amma_pkg::B_IDLE;
      sum       <= '0;
      fill      <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.clear) begin
        sum  <= '0;
        fill <= '0;
        wp   <= '0;
      end else if (pop) begin
        sum  <= sum_next;
        fill <= fill_next;
        wp   <= wp_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hist[ptr] <= q_data.mag;
      dividend  <= sum_next;
      quo       <= '0;
      drem      <= '0;
      dstep     <= '0;
    end
    if (state == amma_pkg::B_DIV) begin
      // restoring divide by the window length, one quotient bit per cycle
      drem     <= qbit ? amma_pkg::LenW'(shifted - (amma_pkg::LenW+1)'(cfg.len))
                       : shifted[amma_pkg::LenW-1:0];
      quo      <= {quo[amma_pkg::SumW-2:0], qbit};
      dividend <= dividend << 1;
      dstep    <= dstep + 1'b1;
    end
    if (load_out) begin
      out_clip <= clip_now;
      out_avg  <= clip_now ? amma_pkg::AvgMax : quo[amma_pkg::AvgW-1:0];
    end
  end

  assign averages.valid             = out_valid;
  assign averages.average_magnitude = out_avg;
  assign averages.clipped           = out_clip;

endmodule

[rtl/core/accel_magnitude_moving_average_core.sv]
// Accelerometer magnitude moving average.
// samples (sink): one x/y/z sample per item plus a restart flag that empties
//   the window before the sample is taken. Taken when valid and ready.
// averages (source): floored mean of the last window_length magnitudes
//   (zero as one, capped at 16), saturated to 32767 with clipped set.
// APB register 0 (window_length, reset 10): writing it empties the window.
// Front: absolute values, three squares on one multiplier, then a
//   16-step square root; no new sample is taken until the last is pushed.
// A two-entry queue separates front and back. Back: window update,
//   20-step divider, output register; the back pops no new item until
//   the last result is in the output register.
// No result until the window is full.
// A stalled result holds in the output register while the back keeps
//   working; once the queue fills, samples.ready stays low.
// Reset (synchronous): window empty, window_length 10, no result pending.
module accel_magnitude_moving_average_core (
  input  logic                          clk,
  input  logic                          rst,
  amma_in_if.sink                       samples,
  amma_out_if.source                    averages,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [amma_pkg::AddrW-1:0]    paddr,
  input  logic [amma_pkg::DataW-1:0]    pwdata,
  output logic [amma_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [amma_pkg::LenW-1:0] window_length;
  logic                      wl_hit;
  logic                      wl_write;
  amma_pkg::amma_cfg_t       cfg;

  logic                      push, q_full, pop, q_empty;
  amma_pkg::amma_mag_t       push_data, q_data;

  assign pready   = 1'b1;
  assign wl_hit   = (paddr[amma_pkg::AddrW-1:2] == amma_pkg::RegWindowLength);
  assign wl_write = psel && penable && pwrite && wl_hit;
  assign prdata   = wl_hit ? amma_pkg::DataW'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= amma_pkg::WlReset;
    end else if (wl_write) begin
      window_length <= pwdata[amma_pkg::LenW-1:0];
    end
  end

  assign cfg.clear = wl_write;
  assign cfg.len   = amma_pkg::eff_len(window_length);

  amma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  amma_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  amma_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .pop      (pop),
    .averages (averages)
  );

endmodule

[rtl/core/amma_checker.sv]
module amma_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_valid,
  input logic                      s_ready,
  input logic                      r_valid,
  input logic                      r_ready,
  input logic [amma_pkg::AvgW-1:0] r_avg,
  input logic                      r_clipped
);

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_avg) && $stable(r_clipped))
    else $error("result changed while stalled");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_clipped |-> r_avg == amma_pkg::AvgMax)
    else $error("clipped result not saturated");

  a_reset: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid after reset");

  // front works on one sample at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> !s_ready)
    else $error("sample taken while front busy");

endmodule

bind accel_magnitude_moving_average_core amma_checker u_amma_checker (
  .clk       (clk),
  .rst       (rst),
  .s_valid   (samples.valid),
  .s_ready   (samples.ready),
  .r_valid   (averages.valid),
  .r_ready   (averages.ready),
  .r_avg     (averages.average_magnitude),
  .r_clipped (averages.clipped)
);
